/* rtl/sme_pkg.sv */
// Shared opcodes, error codes and sequencer control types for the stack machine executor.
`timescale 1ns / 1ps
package sme_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned OPC_W  = 8;
  localparam int unsigned ERR_W  = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH  = 8'd0,
    OP_ADD   = 8'd1,
    OP_SUB   = 8'd2,
    OP_MUL   = 8'd3,
    OP_DIV   = 8'd4,
    OP_SQRT  = 8'd5,
    OP_OUT   = 8'd6,
    OP_HLT   = 8'd7,
    OP_PUSHR = 8'd8,
    OP_POPR  = 8'd9,
    OP_IN    = 8'd10,
    OP_JB    = 8'd11,
    OP_CALL  = 8'd12,
    OP_RET   = 8'd13
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE   = 3'd0,
    ERR_UNDER  = 3'd1,
    ERR_OVER   = 3'd2,
    ERR_ARITH  = 3'd3,
    ERR_REG    = 3'd4,
    ERR_OPCODE = 3'd5,
    ERR_RET    = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    ALU_DIV  = 2'd0,
    ALU_SQRT = 2'd1,
    ALU_MUL  = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic                start;
    alu_op_t             op;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic                done;
    logic [WORD_W-1:0]   result;
  } alu_rsp_t;

  localparam logic [ADDR_W-1:0] PROG_LEN_RESET = 16'd1;

endpackage

/* rtl/sme_if.sv */
// Valid/ready channel interface carrying one payload transaction.
`timescale 1ns / 1ps
interface sme_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sme_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sme_alu.sv */
// Shared multi-cycle unit: radix-2 signed divide, bit-pair square root, multiply.
`timescale 1ns / 1ps
module sme_alu (
  input  logic               clk,
  input  logic               rst,
  input  sme_pkg::alu_req_t  req,
  output sme_pkg::alu_rsp_t  rsp
);
  import sme_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t            state;
  alu_op_t           op;
  logic [5:0]        cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic              neg;
  logic [WORD_W-1:0] res;
  logic              done;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] rem_sh;
  logic [WORD_W-1:0] sq_t;

  assign mag_a  = req.a[WORD_W-1] ? WORD_W'(0) - req.a : req.a;
  assign mag_b  = req.b[WORD_W-1] ? WORD_W'(0) - req.b : req.b;
  assign rem_sh = {rem[WORD_W-2:0], quo[WORD_W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};
  // sqrt: rem holds v, quo holds r, dvs holds bit
  assign sq_t   = quo + dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            op <= req.op;
            unique case (req.op)
              ALU_DIV: begin
                rem   <= '0;
                quo   <= mag_a;
                dvs   <= mag_b;
                neg   <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
                cnt   <= 6'd32;
                state <= S_RUN;
              end
              ALU_SQRT: begin
                rem   <= req.a;
                quo   <= '0;
                dvs   <= 32'h4000_0000;
                cnt   <= 6'd16;
                state <= S_RUN;
              end
              default: begin
                res   <= req.a * req.b;
                state <= S_FIX;
              end
            endcase
          end
        end
        S_RUN: begin
          if (op == ALU_DIV) begin
            if (!trial[WORD_W]) begin
              rem <= trial[WORD_W-1:0];
              quo <= {quo[WORD_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[WORD_W-2:0], 1'b0};
            end
          end else begin
            if (rem >= sq_t) begin
              rem <= rem - sq_t;
              quo <= (quo >> 1) + dvs;
            end else begin
              quo <= quo >> 1;
            end
            dvs <= dvs >> 2;
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (op == ALU_DIV) begin
            res <= neg ? WORD_W'(0) - quo : quo;
          end else if (op == ALU_SQRT) begin
            res <= quo;
          end
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    state == S_FIX |=> done)
    else $error("alu done missing");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |=> state != S_IDLE || $past(cnt) == 6'd1)
    else $error("alu left run early");
endmodule

/* rtl/stack_machine_executor_core.sv */
// Top level: stack machine sequencer with data/return stack RAMs and shared ALU.
// Each instruction passes stack RAM reads (RD1, RD2), execute (EXEC) and result (OUT);
// a stopped machine posts its result from EXEC. Mul, div and sqrt wait in ALU for the
// shared unit, one bit per cycle for div/sqrt. One item at a time; in_ch.ready
// is high only in the idle state with no result waiting. Synchronous active-high
// reset sets pointer 1, depths 0, registers 0, program_length 1; stack RAMs hold no reset.
`timescale 1ns / 1ps
module stack_machine_executor_core #(
  parameter int unsigned DATA_STACK_DEPTH   = 64,
  parameter int unsigned RETURN_STACK_DEPTH = 16,
  parameter int unsigned REGISTER_COUNT     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sme_if.sink         in_ch,
  sme_if.source       out_ch
);
  import sme_pkg::*;

  localparam int unsigned DA_W = $clog2(DATA_STACK_DEPTH);
  localparam int unsigned DD_W = $clog2(DATA_STACK_DEPTH + 1);
  localparam int unsigned RA_W = $clog2(RETURN_STACK_DEPTH);
  localparam int unsigned RD_W = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int unsigned RI_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_ALU, S_OUT} state_t;

  state_t             state;
  logic [ADDR_W-1:0]  prog_len;
  logic [ADDR_W-1:0]  ip;
  logic [DD_W-1:0]    dd;
  logic [RD_W-1:0]    rd;
  logic               stopped;
  logic [WORD_W-1:0]  regs [REGISTER_COUNT];
  logic [OPC_W-1:0]   op;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  cons;
  logic [WORD_W-1:0]  top_b;

  logic               d_we;
  logic [DA_W-1:0]    d_waddr;
  logic [WORD_W-1:0]  d_wdata;
  logic [DA_W-1:0]    d_raddr;
  logic [WORD_W-1:0]  d_rdata;
  logic               r_we;
  logic [RA_W-1:0]    r_waddr;
  logic [ADDR_W-1:0]  r_wdata;
  logic [RA_W-1:0]    r_raddr;
  logic [ADDR_W-1:0]  r_rdata;
  alu_req_t           areq;
  alu_rsp_t           arsp;

  logic [ADDR_W-1:0]  o_addr;
  logic               o_ov;
  logic [WORD_W-1:0]  o_val;
  logic               o_halt;
  logic [ERR_W-1:0]   o_err;
  logic               o_pend;

  logic               reg_ok;
  logic [RI_W-1:0]    reg_ix;
  logic [ADDR_W-1:0]  ip1;
  logic [ADDR_W-1:0]  ip2;

  sme_ram #(.WIDTH(WORD_W), .DEPTH(DATA_STACK_DEPTH)) u_dstack (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  sme_ram #(.WIDTH(ADDR_W), .DEPTH(RETURN_STACK_DEPTH)) u_rstack (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  sme_alu u_alu (.clk(clk), .rst(rst), .req(areq), .rsp(arsp));

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, prog_len} : 32'd0;

  assign ip1    = ip + ADDR_W'(1);
  assign ip2    = ip + ADDR_W'(2);
  assign reg_ok = (word != 0) && (word <= WORD_W'(REGISTER_COUNT));
  assign reg_ix = reg_ok ? RI_W'(word - 1) : '0;

  assign in_ch.ready  = (state == S_IDLE) && !o_pend;
  assign out_ch.valid = o_pend;
  assign out_ch.payload.fetch_address = o_addr;
  assign out_ch.payload.out_valid     = o_ov;
  assign out_ch.payload.out_value     = o_val;
  assign out_ch.payload.halted        = o_halt;
  assign out_ch.payload.error_code    = o_err;

  // stack read addresses: top in RD1, second in RD2
  always_comb begin
    d_raddr = DA_W'(dd - DD_W'(2));
    if (state == S_RD1) begin
      d_raddr = DA_W'(dd - DD_W'(1));
    end
    r_raddr = RA_W'(rd - RD_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      prog_len <= PROG_LEN_RESET;
      ip       <= ADDR_W'(1);
      dd       <= '0;
      rd       <= '0;
      stopped  <= 1'b0;
      o_pend   <= 1'b0;
      d_we     <= 1'b0;
      r_we     <= 1'b0;
      areq.start <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else begin
      d_we       <= 1'b0;
      r_we       <= 1'b0;
      areq.start <= 1'b0;
      if (psel && penable && pwrite && paddr == 2'd0) begin
        prog_len <= pwdata[ADDR_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        o_pend <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            op    <= in_ch.payload.opcode;
            word  <= in_ch.payload.operand_word;
            cons  <= in_ch.payload.console_value;
            state <= S_RD1;
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          top_b <= d_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          o_addr <= ip1;
          o_ov   <= 1'b0;
          o_val  <= '0;
          o_err  <= ERR_NONE;
          state  <= S_OUT;
          if (stopped || ip > prog_len) begin
            stopped <= 1'b1;
            o_addr  <= ip;
            o_halt  <= 1'b1;
            o_pend  <= 1'b1;
            state   <= S_IDLE;
          end else begin
            unique case (op)
              OP_PUSH, OP_IN: begin
                if (dd >= DD_W'(DATA_STACK_DEPTH)) begin
                  o_err <= ERR_OVER;
                end else begin
                  d_we    <= 1'b1;
                  d_waddr <= DA_W'(dd);
                  d_wdata <= (op == OP_PUSH) ? word : cons;
                  dd      <= dd + DD_W'(1);
                  if (op == OP_PUSH) o_addr <= ip2;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (dd < DD_W'(2)) begin
                  o_err <= ERR_UNDER;
                end else if (op == OP_DIV && top_b == '0) begin
                  o_err <= ERR_ARITH;
                end else if (op == OP_ADD || op == OP_SUB) begin
                  d_we    <= 1'b1;
                  d_waddr <= DA_W'(dd - DD_W'(2));
                  d_wdata <= (op == OP_ADD) ? d_rdata + top_b : d_rdata - top_b;
                  dd      <= dd - DD_W'(1);
                end else begin
                  areq.start <= 1'b1;
                  areq.op    <= (op == OP_MUL) ? ALU_MUL : ALU_DIV;
                  areq.a     <= d_rdata;
                  areq.b     <= top_b;
                  state      <= S_ALU;
                end
              end
              OP_SQRT: begin
                if (dd < DD_W'(1)) begin
                  o_err <= ERR_UNDER;
                end else if (top_b[WORD_W-1]) begin
                  o_err <= ERR_ARITH;
                end else begin
                  areq.start <= 1'b1;
                  areq.op    <= ALU_SQRT;
                  areq.a     <= top_b;
                  areq.b     <= '0;
                  state      <= S_ALU;
                end
              end
              OP_OUT: begin
                if (dd < DD_W'(1)) begin
                  o_err <= ERR_UNDER;
                end else begin
                  o_ov  <= 1'b1;
                  o_val <= top_b;
                  dd    <= dd - DD_W'(1);
                end
              end
              OP_HLT: o_addr <= ip;
              OP_PUSHR: begin
                if (!reg_ok) begin
                  o_err <= ERR_REG;
                end else if (dd >= DD_W'(DATA_STACK_DEPTH)) begin
                  o_err <= ERR_OVER;
                end else begin
                  d_we    <= 1'b1;
                  d_waddr <= DA_W'(dd);
                  d_wdata <= regs[reg_ix];
                  dd      <= dd + DD_W'(1);
                  o_addr  <= ip2;
                end
              end
              OP_POPR: begin
                if (!reg_ok) begin
                  o_err <= ERR_REG;
                end else if (dd < DD_W'(1)) begin
                  o_err <= ERR_UNDER;
                end else begin
                  regs[reg_ix] <= top_b;
                  dd           <= dd - DD_W'(1);
                  o_addr       <= ip2;
                end
              end
              OP_JB: begin
                if (dd < DD_W'(2)) begin
                  o_err <= ERR_UNDER;
                end else begin
                  dd     <= dd - DD_W'(2);
                  o_addr <= ($signed(d_rdata) < $signed(top_b)) ? word[ADDR_W-1:0] : ip2;
                end
              end
              OP_CALL: begin
                if (rd >= RD_W'(RETURN_STACK_DEPTH)) begin
                  o_err <= ERR_RET;
                end else begin
                  r_we    <= 1'b1;
                  r_waddr <= RA_W'(rd);
                  r_wdata <= ip2;
                  rd      <= rd + RD_W'(1);
                  o_addr  <= word[ADDR_W-1:0];
                end
              end
              OP_RET: begin
                if (rd < RD_W'(1)) begin
                  o_err <= ERR_RET;
                end else begin
                  rd     <= rd - RD_W'(1);
                  o_addr <= r_rdata;
                end
              end
              default: o_err <= ERR_OPCODE;
            endcase
          end
        end
        S_ALU: begin
          if (arsp.done) begin
            d_we    <= 1'b1;
            d_waddr <= DA_W'(dd - DD_W'(op == OP_SQRT ? 1 : 2));
            d_wdata <= arsp.result;
            if (op != OP_SQRT) dd <= dd - DD_W'(1);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          o_pend <= 1'b1;
          state  <= S_IDLE;
          if (o_err != ERR_NONE && o_err != ERR_OPCODE) begin
            o_addr  <= ip;
            o_halt  <= 1'b1;
            stopped <= 1'b1;
            o_ov    <= 1'b0;
            o_val   <= '0;
          end else begin
            ip <= o_addr;
            o_halt <= (op == OP_HLT) || (o_addr > prog_len);
            if ((op == OP_HLT) || (o_addr > prog_len)) stopped <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE && !o_pend)
    else $error("ready outside idle");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    dd <= DD_W'(DATA_STACK_DEPTH) && rd <= RD_W'(RETURN_STACK_DEPTH))
    else $error("stack depth past limit");
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    o_pend && o_err != ERR_NONE && o_err != ERR_OPCODE |-> o_halt)
    else $error("error without halt");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $rose(o_pend) |-> $past(state) == S_OUT || $past(state) == S_EXEC)
    else $error("result from wrong state");
endmodule

/* tb/stack_machine_executor_core_tb.sv */
// Testbench for the stack machine executor core: drives instruction transactions and checks each result.
`timescale 1ns / 1ps
module stack_machine_executor_core_tb;
  import sme_pkg::*;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] operand_word;
    logic [31:0] console_value;
  } instr_t;

  typedef struct packed {
    logic [15:0] fetch_address;
    logic        out_valid;
    logic [31:0] out_value;
    logic        halted;
    logic [2:0]  error_code;
  } step_result_t;

  localparam int DSTK_DEPTH = 64;
  localparam int RSTK_DEPTH = 16;
  localparam int NREGS = 8;

  class exec_scoreboard;
    logic [15:0] prog_len;
    logic [15:0] ip;
    logic [31:0] dstk[DSTK_DEPTH];
    int          dd;
    logic [15:0] rstk[RSTK_DEPTH];
    int          rd;
    logic [31:0] regs[NREGS];
    bit          stopped;
    step_result_t pending[$];
    int          errors;

    function new();
      prog_len = 16'd1;
      ip = 16'd1;
      dd = 0;
      rd = 0;
      foreach (regs[i]) regs[i] = '0;
      stopped = 0;
      errors = 0;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function logic [31:0] isqrt(logic [31:0] v);
      logic [31:0] r;
      logic [31:0] b;
      r = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
      if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
      return $signed(a) / $signed(b);
    endfunction

    function step_result_t execute(instr_t it);
      step_result_t res;
      logic [15:0] nxt;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] w;
      err_t        err;
      bit          halt;
      res = '0;
      nxt = ip + 16'd1;
      err = ERR_NONE;
      halt = 0;
      w = it.operand_word;
      if (stopped || ip > prog_len) begin
        stopped = 1;
        res.fetch_address = ip;
        res.halted = 1;
        return res;
      end
      case (it.opcode)
        OP_PUSH, OP_IN: begin
          if (dd >= DSTK_DEPTH) err = ERR_OVER;
          else begin
            dstk[dd] = (it.opcode == OP_PUSH) ? w : it.console_value;
            dd++;
            if (it.opcode == OP_PUSH) nxt = ip + 16'd2;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (dd < 2) err = ERR_UNDER;
          else begin
            a = dstk[dd-2];
            b = dstk[dd-1];
            if (it.opcode == OP_DIV && b == 0) err = ERR_ARITH;
            else begin
              dd--;
              case (it.opcode)
                OP_ADD: dstk[dd-1] = a + b;
                OP_SUB: dstk[dd-1] = a - b;
                OP_MUL: dstk[dd-1] = a * b;
                default: dstk[dd-1] = sdiv(a, b);
              endcase
            end
          end
        end
        OP_SQRT: begin
          if (dd < 1) err = ERR_UNDER;
          else if (dstk[dd-1][31]) err = ERR_ARITH;
          else dstk[dd-1] = isqrt(dstk[dd-1]);
        end
        OP_OUT: begin
          if (dd < 1) err = ERR_UNDER;
          else begin
            dd--;
            res.out_valid = 1;
            res.out_value = dstk[dd];
          end
        end
        OP_HLT: begin
          halt = 1;
          nxt = ip;
        end
        OP_PUSHR, OP_POPR: begin
          if (w < 1 || w > NREGS) err = ERR_REG;
          else if (it.opcode == OP_PUSHR) begin
            if (dd >= DSTK_DEPTH) err = ERR_OVER;
            else begin
              dstk[dd] = regs[w-1];
              dd++;
              nxt = ip + 16'd2;
            end
          end else begin
            if (dd < 1) err = ERR_UNDER;
            else begin
              dd--;
              regs[w-1] = dstk[dd];
              nxt = ip + 16'd2;
            end
          end
        end
        OP_JB: begin
          if (dd < 2) err = ERR_UNDER;
          else begin
            a = dstk[dd-2];
            b = dstk[dd-1];
            dd -= 2;
            nxt = ($signed(a) < $signed(b)) ? w[15:0] : ip + 16'd2;
          end
        end
        OP_CALL: begin
          if (rd >= RSTK_DEPTH) err = ERR_RET;
          else begin
            rstk[rd] = ip + 16'd2;
            rd++;
            nxt = w[15:0];
          end
        end
        OP_RET: begin
          if (rd < 1) err = ERR_RET;
          else begin
            rd--;
            nxt = rstk[rd];
          end
        end
        default: err = ERR_OPCODE;
      endcase
      if (err != ERR_NONE && err != ERR_OPCODE) begin
        halt = 1;
        nxt = ip;
        res.out_valid = 0;
        res.out_value = 0;
      end
      ip = nxt;
      if (halt || nxt > prog_len) begin
        stopped = 1;
        halt = 1;
      end
      res.fetch_address = nxt;
      res.halted = halt;
      res.error_code = err;
      return res;
    endfunction

    function void note_instr(instr_t it);
      pending.push_back(execute(it));
    endfunction

    task check_result(step_result_t got);
      step_result_t exp;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.fetch_address !== exp.fetch_address)
        report($sformatf("fetch_address %0d, want %0d", got.fetch_address, exp.fetch_address));
      if (got.out_valid !== exp.out_valid)
        report($sformatf("out_valid %0b, want %0b", got.out_valid, exp.out_valid));
      if (got.out_value !== exp.out_value)
        report($sformatf("out_value %h, want %h", got.out_value, exp.out_value));
      if (got.halted !== exp.halted)
        report($sformatf("halted %0b, want %0b", got.halted, exp.halted));
      if (got.error_code !== exp.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, exp.error_code));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sme_if #(.payload_t(instr_t))       in_ch ();
  sme_if #(.payload_t(step_result_t)) out_ch ();

  stack_machine_executor_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  exec_scoreboard sb;
  int snd_idle;
  int rcv_idle;
  int hold_cycles;

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_instr(in_ch.payload);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
    end
  end

  task automatic write_prog_len(logic [15:0] len);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 2'd0;
    pwdata <= {16'd0, len};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.prog_len = len;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send(instr_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(logic [7:0] op, logic [31:0] w, logic [31:0] c = $urandom);
    instr_t it;
    it.opcode = op;
    it.operand_word = w;
    it.console_value = c;
    send(it);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: case ($urandom_range(3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'hFFFF_FFFF;
           default: return 32'h0;
         endcase
      1: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // draw an instruction that keeps the machine running
  function automatic instr_t legal_instr();
    instr_t it;
    bit ok;
    it.operand_word = pick_value();
    it.console_value = pick_value();
    if (int'(sb.ip) + 2 > int'(sb.prog_len)) begin
      it.opcode = (sb.rd < RSTK_DEPTH) ? OP_CALL : OP_RET;
      it.operand_word = $urandom_range(0, 200);
      return it;
    end
    ok = 0;
    while (!ok) begin
      if ($urandom_range(99) < 8) it.opcode = 8'($urandom_range(14, 255));
      else it.opcode = 8'($urandom_range(0, 13));
      case (it.opcode)
        OP_PUSH, OP_IN: ok = sb.dd < DSTK_DEPTH;
        OP_ADD, OP_SUB, OP_MUL: ok = sb.dd >= 2;
        OP_DIV: ok = sb.dd >= 2 && sb.dstk[sb.dd-1] != 0;
        OP_SQRT: ok = sb.dd >= 1 && !sb.dstk[sb.dd-1][31];
        OP_OUT: ok = sb.dd >= 1;
        OP_HLT: ok = 0;
        OP_PUSHR: ok = sb.dd < DSTK_DEPTH;
        OP_POPR: ok = sb.dd >= 1;
        OP_JB: ok = sb.dd >= 2;
        OP_CALL: ok = sb.rd < RSTK_DEPTH;
        OP_RET: ok = sb.rd >= 1;
        default: ok = 1;
      endcase
    end
    if (it.opcode == OP_PUSHR || it.opcode == OP_POPR)
      it.operand_word = $urandom_range(1, NREGS);
    if (it.opcode == OP_JB || it.opcode == OP_CALL)
      it.operand_word = {16'($urandom), 16'(0)} | $urandom_range(0, sb.prog_len);
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send(legal_instr());
  endtask

  // end the program with a halt or one fatal fault chosen at random
  task automatic fatal_tail();
    case ($urandom_range(6))
      0: send_op(OP_HLT, $urandom);
      1: send_op(OP_PUSHR, $urandom_range(1) ? 32'd0 : 32'd9);
      2: begin
        send_op(OP_PUSH, 32'd5);
        send_op(OP_PUSH, 32'd0);
        send_op(OP_DIV, $urandom);
      end
      3: begin
        send_op(OP_PUSH, 32'hFFFF_FFFB);
        send_op(OP_SQRT, $urandom);
      end
      4: begin
        while (sb.dd > 0 && !sb.stopped) send_op(OP_OUT, $urandom);
        send_op(OP_OUT, $urandom);
      end
      5: begin
        while (sb.dd < DSTK_DEPTH && !sb.stopped) send_op(OP_IN, $urandom);
        send_op(OP_PUSH, $urandom);
      end
      default: begin
        while (sb.rd > 0 && !sb.stopped) send_op(OP_RET, $urandom);
        send_op(OP_RET, $urandom);
      end
    endcase
  endtask

  initial begin
    sb = new();
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 0;
    in_ch.payload = '0;
    out_ch.ready = 0;
    snd_idle = 21;
    rcv_idle = 76;
    hold_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_prog_len(16'hFFFF);
    send_op(OP_PUSH, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 32'd1);
    send_op(OP_ADD, 32'd0);
    send_op(OP_PUSH, 32'hFFFF_FFFF);
    send_op(OP_DIV, 32'd0);
    send_op(OP_PUSH, 32'd7);
    send_op(OP_SUB, 32'd0);
    send_op(OP_PUSH, 32'hFFFF_FFFD);
    send_op(OP_MUL, 32'd0);
    send_op(OP_IN, 32'd0, 32'h7FFF_FFFF);
    send_op(OP_SQRT, 32'd0);
    send_op(OP_OUT, 32'd0);
    send_op(OP_POPR, 32'd8);
    send_op(OP_PUSHR, 32'd8);
    send_op(OP_PUSHR, 32'd1);
    send_op(OP_JB, 32'h0000_FFF0);
    send_op(OP_CALL, 32'd100);
    send_op(OP_RET, 32'd0);
    send_op(8'hFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_op(8'd14, 32'd0);
    send_op(OP_PUSH, 32'd5);
    send_op(OP_PUSH, 32'hFFFF_FFFE);
    send_op(OP_DIV, 32'd0);
    send_op(OP_OUT, 32'd0);
    run_random(200);

    in_ch.valid <= 0;
    drain();
    write_prog_len(16'($urandom_range(40000, 65535)) | sb.ip);
    snd_idle = 76;
    rcv_idle = 21;
    run_random(200);

    in_ch.valid <= 0;
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    hold_cycles = 400;
    run_random(200);
    fatal_tail();
    repeat (5) send_op(8'($urandom), $urandom, $urandom);

    in_ch.valid <= 0;
    drain();
    write_prog_len(16'd1);
    repeat (5) send_op(8'($urandom), $urandom, $urandom);
    in_ch.valid <= 0;

    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

/* sim.f */
rtl/sme_pkg.sv
rtl/sme_if.sv
rtl/sme_ram.sv
rtl/sme_alu.sv
rtl/stack_machine_executor_core.sv
tb/stack_machine_executor_core_tb.sv
